### hdl/ldkfd_pkg.sv
// shared types, command codes and tables for the led digit and key frame driver
package ldkfd_pkg;

	localparam logic [7:0] CMD_FIXED   = 8'h44;
	localparam logic [7:0] CMD_ADDR    = 8'hC0;
	localparam logic [7:0] CMD_DISP_ON = 8'h8F;
	localparam logic [7:0] CMD_KEY     = 8'h42;
	localparam logic [7:0] KEY_MASK    = 8'h66;

	localparam logic [31:0] KEY_PAT_1 = 32'h0400_0000;
	localparam logic [31:0] KEY_PAT_2 = 32'h4000_0000;
	localparam logic [31:0] KEY_PAT_3 = 32'h0004_0000;
	localparam logic [31:0] KEY_PAT_4 = 32'h0040_0000;
	localparam logic [31:0] KEY_PAT_5 = 32'h0000_0400;
	localparam logic [31:0] KEY_PAT_6 = 32'h0000_4000;

	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_1    = 3'd1;
	localparam logic [2:0] KEY_2    = 3'd2;
	localparam logic [2:0] KEY_3    = 3'd3;
	localparam logic [2:0] KEY_4    = 3'd4;
	localparam logic [2:0] KEY_5    = 3'd5;
	localparam logic [2:0] KEY_6    = 3'd6;

	localparam int QUEUE_DEPTH = 2;

	// one classified request between front and back
	typedef struct packed {
		logic             is_key;
		logic [2:0]       key;
		logic [7:0][3:0]  grp_data;
	} desc_t;

	// seven-segment pattern, blank for anything above nine
	function automatic logic [6:0] seg_pattern(input logic [3:0] d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h3F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5B;
			4'd3: p = 7'h4F;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6D;
			4'd6: p = 7'h7D;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h6F;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

### hdl/ldkfd_front.sv
// front end: classifies a request and builds its descriptor
module ldkfd_front (
	input  logic              func,
	input  logic [3:0]        digit_one,
	input  logic [3:0]        digit_two,
	input  logic [3:0]        digit_three,
	input  logic [3:0]        digit_four,
	input  logic [2:0]        point_pos,
	input  logic [7:0]        scan_byte_zero,
	input  logic [7:0]        scan_byte_one,
	input  logic [7:0]        scan_byte_two,
	input  logic [7:0]        scan_byte_three,
	output ldkfd_pkg::desc_t  desc
);
	import ldkfd_pkg::*;

	logic [6:0]  p1, p2, p3, p4;
	logic [31:0] scan_code;
	logic [3:0]  pt_data;
	logic [2:0]  key;

	assign p1 = seg_pattern(digit_one);
	assign p2 = seg_pattern(digit_two);
	assign p3 = seg_pattern(digit_three);
	assign p4 = seg_pattern(digit_four);

	assign scan_code = {scan_byte_zero & KEY_MASK, scan_byte_one & KEY_MASK,
		scan_byte_two & KEY_MASK, scan_byte_three & KEY_MASK};

	always_comb begin
		case (scan_code)
			KEY_PAT_1: key = KEY_1;
			KEY_PAT_2: key = KEY_2;
			KEY_PAT_3: key = KEY_3;
			KEY_PAT_4: key = KEY_4;
			KEY_PAT_5: key = KEY_5;
			KEY_PAT_6: key = KEY_6;
			default:   key = KEY_NONE;
		endcase
	end

	// point sits at bit 3 for the leftmost digit down to bit 0
	always_comb begin
		if (point_pos inside {[3'd1:3'd4]}) begin
			pt_data = 4'(4'b0001 << (3'd4 - point_pos));
		end else begin
			pt_data = 4'b0000;
		end
	end

	always_comb begin
		desc.is_key = func;
		desc.key    = func ? key : KEY_NONE;
		for (int i = 0; i < 7; i++) begin
			desc.grp_data[i] = {p1[i], p2[i], p3[i], p4[i]};
		end
		desc.grp_data[7] = pt_data;
	end

endmodule

### hdl/ldkfd_queue.sv
// short descriptor queue between front and back
module ldkfd_queue #(
	parameter int DEPTH = ldkfd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ldkfd_pkg::desc_t  push_data,
	output logic              full,
	input  logic              pop,
	output ldkfd_pkg::desc_t  pop_data,
	output logic              empty
);
	import ldkfd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count above depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("queue count missed a push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("queue count missed a pop");

endmodule

### hdl/ldkfd_back.sv
// back end: walks a descriptor and emits frame words into the output register
module ldkfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ldkfd_pkg::desc_t  q_data,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic              strobe_start,
	output logic [7:0]        out_byte,
	output logic [2:0]        key_num,
	output logic              last
);
	import ldkfd_pkg::*;

	typedef enum logic [1:0] {PH_FIX, PH_ADDR, PH_DATA, PH_ON} phase_t;

	phase_t      ph_q;
	logic [2:0]  grp_q;
	logic        act_q, ov_q;
	desc_t       desc_q;
	logic        w_strobe, w_last, adv, load;
	logic [7:0]  w_byte;
	logic [2:0]  w_key;

	always_comb begin
		w_key = KEY_NONE;
		if (desc_q.is_key) begin
			w_strobe = 1'b1;
			w_byte   = CMD_KEY;
			w_key    = desc_q.key;
			w_last   = 1'b1;
		end else begin
			case (ph_q)
				PH_FIX: begin
					w_strobe = 1'b1;
					w_byte   = CMD_FIXED;
					w_last   = 1'b0;
				end
				PH_ADDR: begin
					w_strobe = 1'b1;
					w_byte   = CMD_ADDR | {4'b0000, grp_q, 1'b0};
					w_last   = 1'b0;
				end
				PH_DATA: begin
					w_strobe = 1'b0;
					w_byte   = {4'b0000, desc_q.grp_data[grp_q]};
					w_last   = 1'b0;
				end
				default: begin
					w_strobe = 1'b1;
					w_byte   = CMD_DISP_ON;
					w_last   = 1'b1;
				end
			endcase
		end
	end

	// output register free or being drained
	assign adv   = !ov_q || pop;
	assign load  = act_q ? (adv && w_last && !q_empty) : !q_empty;
	assign q_pop = load;
	assign empty = !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q         <= PH_FIX;
			grp_q        <= '0;
			act_q        <= 1'b0;
			ov_q         <= 1'b0;
			desc_q       <= '0;
			strobe_start <= 1'b0;
			out_byte     <= '0;
			key_num      <= KEY_NONE;
			last         <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= act_q;
			end
			if (adv && act_q) begin
				strobe_start <= w_strobe;
				out_byte     <= w_byte;
				key_num      <= w_key;
				last         <= w_last;
				if (!desc_q.is_key) begin
					case (ph_q)
						PH_FIX:  ph_q <= PH_ADDR;
						PH_ADDR: ph_q <= PH_DATA;
						PH_DATA: begin
							ph_q  <= (grp_q == 3'd7) ? PH_ON : PH_FIX;
							grp_q <= grp_q + 3'd1;
						end
						default: begin
							ph_q  <= PH_FIX;
							grp_q <= '0;
						end
					endcase
				end
			end
			if (load) begin
				desc_q <= q_data;
				act_q  <= 1'b1;
			end else if (act_q && adv && w_last) begin
				act_q <= 1'b0;
			end
		end
	end

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !strobe_start |-> !last && out_byte[7:4] == 4'b0000)
		else $error("data word marked last or too wide");
	a_key_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && key_num != KEY_NONE |-> last && out_byte == CMD_KEY)
		else $error("key number outside a key word");
	a_on_display: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && ph_q == PH_ON |-> !desc_q.is_key)
		else $error("key request reached display-on phase");
	a_key_phase: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && desc_q.is_key |-> ph_q == PH_FIX && grp_q == 3'd0)
		else $error("key request started mid frame");

endmodule

### hdl/led_digit_key_frame_driver_top.sv
// top level of the led digit and key frame driver
//
// input side is a queue: a request word is taken on a clock edge with push high
// and full low. func 0 asks for a display frame built from four digits and a
// point position; func 1 asks for the key scan command and a decoded key number.
// result side is a queue too: while empty is low the oldest frame byte sits on
// strobe_start, out_byte, key_num and last; it is taken on an edge with pop high.
// a display request gives 25 words (eight groups of fixed-address command,
// address command and data byte, then display-on); a key request gives one.
// an accepted request passes the descriptor queue and the back end's descriptor
// register before its first word is in the output register. the back end emits
// one word per cycle while not stalled, and frame length sets the request rate.
// the front classifies in the accepting cycle and a short descriptor queue
// lets new requests in while the back end is still sending.
// when the receiver stalls the output register holds its word and the back
// end waits; full rises once the descriptor queue fills.
// reset (arst_n low) empties both queues and idles the sequencer.
module led_digit_key_frame_driver_top #(
	parameter int QDEPTH = ldkfd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [3:0]  digit_one,
	input  logic [3:0]  digit_two,
	input  logic [3:0]  digit_three,
	input  logic [3:0]  digit_four,
	input  logic [2:0]  point_pos,
	input  logic [7:0]  scan_byte_zero,
	input  logic [7:0]  scan_byte_one,
	input  logic [7:0]  scan_byte_two,
	input  logic [7:0]  scan_byte_three,
	output logic        empty,
	input  logic        pop,
	output logic        strobe_start,
	output logic [7:0]  out_byte,
	output logic [2:0]  key_num,
	output logic        last
);
	import ldkfd_pkg::*;

	// descriptor from the front, and the one at the queue head
	desc_t  front_desc;
	desc_t  head_desc;
	logic   q_empty;
	logic   q_pop;

	// segment lookup, transposition, point and key decode
	ldkfd_front u_front (
		.func            (func),
		.digit_one       (digit_one),
		.digit_two       (digit_two),
		.digit_three     (digit_three),
		.digit_four      (digit_four),
		.point_pos       (point_pos),
		.scan_byte_zero  (scan_byte_zero),
		.scan_byte_one   (scan_byte_one),
		.scan_byte_two   (scan_byte_two),
		.scan_byte_three (scan_byte_three),
		.desc            (front_desc)
	);

	// the front's push is the input handshake itself
	ldkfd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_desc),
		.full      (full),
		.pop       (q_pop),
		.pop_data  (head_desc),
		.empty     (q_empty)
	);

	// frame sequencer with its output register
	ldkfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (head_desc),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.strobe_start (strobe_start),
		.out_byte     (out_byte),
		.key_num      (key_num),
		.last         (last)
	);

endmodule

### dv/tb.sv
// testbench for the led digit and key frame driver: directed and random requests against a scoreboard
module tb;
	import ldkfd_pkg::*;

	// one request word as offered on the input side
	typedef struct packed {
		logic       func;
		logic [3:0] digit_one;
		logic [3:0] digit_two;
		logic [3:0] digit_three;
		logic [3:0] digit_four;
		logic [2:0] point_pos;
		logic [7:0] scan_byte_zero;
		logic [7:0] scan_byte_one;
		logic [7:0] scan_byte_two;
		logic [7:0] scan_byte_three;
	} request_t;

	// one frame byte as seen on the result side
	typedef struct packed {
		logic       strobe_start;
		logic [7:0] out_byte;
		logic [2:0] key_num;
		logic       last;
	} frame_word_t;

	// segment patterns a..g in bits 0..6, entry 0 rightmost; ten and above are blank
	localparam logic [15:0][6:0] SEG_TABLE = {
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h6F, 7'h7F,
		7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	localparam int HOLD_CYCLES = 150;

	// works out the frame bytes of each accepted request and checks the bytes that come out
	class frame_board;
		frame_word_t expected_words[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		function logic [2:0] decode_key(request_t r);
			logic [31:0] code;
			code = {r.scan_byte_zero & KEY_MASK, r.scan_byte_one & KEY_MASK,
			        r.scan_byte_two & KEY_MASK, r.scan_byte_three & KEY_MASK};
			if (code == KEY_PAT_1) return KEY_1;
			if (code == KEY_PAT_2) return KEY_2;
			if (code == KEY_PAT_3) return KEY_3;
			if (code == KEY_PAT_4) return KEY_4;
			if (code == KEY_PAT_5) return KEY_5;
			if (code == KEY_PAT_6) return KEY_6;
			return KEY_NONE;
		endfunction

		function void note_request(request_t r);
			logic [6:0] s1, s2, s3, s4;
			logic [7:0] data;
			if (r.func) begin
				expected_words.push_back({1'b1, CMD_KEY, decode_key(r), 1'b1});
				return;
			end
			s1 = SEG_TABLE[r.digit_one];
			s2 = SEG_TABLE[r.digit_two];
			s3 = SEG_TABLE[r.digit_three];
			s4 = SEG_TABLE[r.digit_four];
			for (int i = 0; i < 8; i++) begin
				if (i < 7) begin
					data = {4'b0, s1[i], s2[i], s3[i], s4[i]};
				end else if (r.point_pos >= 3'd1 && r.point_pos <= 3'd4) begin
					data = 8'd1 << (3'd4 - r.point_pos);
				end else begin
					data = 8'd0;
				end
				expected_words.push_back({1'b1, CMD_FIXED, KEY_NONE, 1'b0});
				expected_words.push_back({1'b1, CMD_ADDR | {4'b0, i[2:0], 1'b0}, KEY_NONE, 1'b0});
				expected_words.push_back({1'b0, data, KEY_NONE, 1'b0});
			end
			expected_words.push_back({1'b1, CMD_DISP_ON, KEY_NONE, 1'b1});
		endfunction

		function void check_word(frame_word_t got);
			frame_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: strobe %0b byte %h key %0d last %0b",
					         got.strobe_start, got.out_byte, got.key_num, got.last);
				return;
			end
			want = expected_words.pop_front();
			if (got.strobe_start !== want.strobe_start || got.out_byte !== want.out_byte ||
			    got.key_num !== want.key_num || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0b %h %0d %0b got %0b %h %0d %0b",
					         want.strobe_start, want.out_byte, want.key_num, want.last,
					         got.strobe_start, got.out_byte, got.key_num, got.last);
			end
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction
	endclass

	// every input starts at a known value
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic       func = 1'b0;
	logic [3:0] digit_one = '0;
	logic [3:0] digit_two = '0;
	logic [3:0] digit_three = '0;
	logic [3:0] digit_four = '0;
	logic [2:0] point_pos = '0;
	logic [7:0] scan_byte_zero = '0;
	logic [7:0] scan_byte_one = '0;
	logic [7:0] scan_byte_two = '0;
	logic [7:0] scan_byte_three = '0;
	logic       full;
	logic       empty;
	logic       strobe_start;
	logic [7:0] out_byte;
	logic [2:0] key_num;
	logic       last;

	// idling switches for each side, and the hold-off requests for the receiver
	bit send_idling = 1'b1;
	bit recv_idling = 1'b1;
	int hold_requests = 0;

	frame_board board = new();

	led_digit_key_frame_driver_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.digit_one(digit_one),
		.digit_two(digit_two),
		.digit_three(digit_three),
		.digit_four(digit_four),
		.point_pos(point_pos),
		.scan_byte_zero(scan_byte_zero),
		.scan_byte_one(scan_byte_one),
		.scan_byte_two(scan_byte_two),
		.scan_byte_three(scan_byte_three),
		.empty(empty),
		.pop(pop),
		.strobe_start(strobe_start),
		.out_byte(out_byte),
		.key_num(key_num),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// display request with random scan bytes, which the block should ignore
	function automatic request_t display_request(logic [3:0] d1, logic [3:0] d2,
	                                             logic [3:0] d3, logic [3:0] d4,
	                                             logic [2:0] pt);
		request_t r;
		r.func = 1'b0;
		r.digit_one = d1;
		r.digit_two = d2;
		r.digit_three = d3;
		r.digit_four = d4;
		r.point_pos = pt;
		{r.scan_byte_zero, r.scan_byte_one, r.scan_byte_two, r.scan_byte_three} = $urandom;
		return r;
	endfunction

	// key request: scan bytes carry the code, plus noise on the bits the decoder masks off
	function automatic request_t key_request(logic [31:0] code, logic [31:0] noise);
		request_t r;
		r.func = 1'b1;
		{r.digit_one, r.digit_two, r.digit_three, r.digit_four} = 16'($urandom);
		r.point_pos = 3'($urandom_range(0, 7));
		{r.scan_byte_zero, r.scan_byte_one, r.scan_byte_two, r.scan_byte_three} =
			code | (noise & {4{~KEY_MASK}});
		return r;
	endfunction

	// mostly real digits, a quarter of the time a blank code above nine
	function automatic logic [3:0] pick_digit();
		if ($urandom_range(0, 3) == 0) return 4'($urandom_range(10, 15));
		return 4'($urandom_range(0, 9));
	endfunction

	// offer one request word, with random idle cycles, until the block takes it
	task automatic send_request(input request_t r);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (send_idling && $urandom_range(0, 99) < 31) begin
				push <= 1'b0;
			end else begin
				func <= r.func;
				digit_one <= r.digit_one;
				digit_two <= r.digit_two;
				digit_three <= r.digit_three;
				digit_four <= r.digit_four;
				point_pos <= r.point_pos;
				scan_byte_zero <= r.scan_byte_zero;
				scan_byte_one <= r.scan_byte_one;
				scan_byte_two <= r.scan_byte_two;
				scan_byte_three <= r.scan_byte_three;
				push <= 1'b1;
				// full is sampled at the edge that would take the word
				@(posedge clk);
				if (!full) begin
					taken = 1'b1;
					board.note_request(r);
				end
			end
		end
	endtask

	// receiver: pop changes on the falling edge, words are taken at the rising edge
	initial begin
		frame_word_t got;
		int          hold_left;
		int          hold_served;
		hold_left = 0;
		hold_served = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// a long hold-off, counted here, lets the block fill and push back
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (recv_idling && $urandom_range(0, 99) < 31) begin
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				got.strobe_start = strobe_start;
				got.out_byte = out_byte;
				got.key_num = key_num;
				got.last = last;
				board.check_word(got);
			end
		end
	end

	// main sequence: reset, directed requests, random requests, drain
	initial begin
		request_t r;
		int       choice;
		logic [31:0] pattern;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every digit code in some position, every point position
		send_request(display_request(4'd0, 4'd1, 4'd2, 4'd3, 3'd1));
		send_request(display_request(4'd4, 4'd5, 4'd6, 4'd7, 3'd2));
		send_request(display_request(4'd8, 4'd9, 4'd10, 4'd11, 3'd3));
		send_request(display_request(4'd12, 4'd13, 4'd14, 4'd15, 3'd4));
		send_request(display_request(4'd15, 4'd15, 4'd15, 4'd15, 3'd0));
		send_request(display_request(4'd0, 4'd0, 4'd0, 4'd0, 3'd5));
		send_request(display_request(4'd9, 4'd8, 4'd8, 4'd8, 3'd7));
		send_request(display_request(4'd1, 4'd2, 4'd3, 4'd4, 3'd6));
		// each key pattern on its own
		send_request(key_request(KEY_PAT_1, 32'd0));
		send_request(key_request(KEY_PAT_2, 32'd0));
		send_request(key_request(KEY_PAT_3, 32'd0));
		send_request(key_request(KEY_PAT_4, 32'd0));
		send_request(key_request(KEY_PAT_5, 32'd0));
		send_request(key_request(KEY_PAT_6, 32'd0));
		// no key, every masked bit set, masked-off bits set, two keys at once, all bits set
		send_request(key_request(32'd0, 32'd0));
		send_request(key_request({4{KEY_MASK}}, 32'd0));
		send_request(key_request(KEY_PAT_1, 32'hFFFF_FFFF));
		send_request(key_request(KEY_PAT_2 | KEY_PAT_5, 32'd0));
		send_request(key_request(32'hFFFF_FFFF, 32'd0));

		for (int n = 0; n < 300; n++) begin
			// receiver goes quiet while requests keep coming
			if (n == 100) hold_requests++;
			// sender waits for the whole backlog to come out
			if (n == 200) begin
				@(negedge clk);
				push <= 1'b0;
				while (board.outstanding() != 0) @(posedge clk);
			end
			// a stretch at full rate on both sides
			if (n == 220) begin
				send_idling = 1'b0;
				recv_idling = 1'b0;
			end
			if (n == 280) begin
				send_idling = 1'b1;
				recv_idling = 1'b1;
			end
			choice = $urandom_range(0, 99);
			if (choice < 45) begin
				r = display_request(pick_digit(), pick_digit(), pick_digit(), pick_digit(),
				                    3'($urandom_range(0, 7)));
			end else if (choice < 85) begin
				case ($urandom_range(1, 6))
					1: pattern = KEY_PAT_1;
					2: pattern = KEY_PAT_2;
					3: pattern = KEY_PAT_3;
					4: pattern = KEY_PAT_4;
					5: pattern = KEY_PAT_5;
					default: pattern = KEY_PAT_6;
				endcase
				r = key_request(pattern, $urandom);
			end else begin
				// noise on the scan bytes, almost always no key
				r = key_request($urandom, 32'd0);
			end
			send_request(r);
		end

		@(negedge clk);
		push <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		// run on to catch any stray word
		repeat (50) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

endmodule

### files.f
hdl/ldkfd_pkg.sv
hdl/ldkfd_front.sv
hdl/ldkfd_queue.sv
hdl/ldkfd_back.sv
hdl/led_digit_key_frame_driver_top.sv
dv/tb.sv
